[src/pool_free_list_allocator_assert.svh]
// Assertion macros used by the pool allocator top level.
`ifndef POOL_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define POOL_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define PFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define PFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pfl_pkg.sv]
// Types and constants for the pool free-list allocator.
`default_nettype none

package pfl_pkg;

  localparam int VAL_W = 32;
  localparam int REC_W = 3 * VAL_W;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_e_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

[src/pool_free_list_allocator.sv]
// Pool free-list allocator top level: FSM controller plus free-list datapath.
// The request is latched and the link, flag and record RAM reads are issued at
//   capture; the result register loads at commit, which waits in the execute
//   state until the output register has drained. A new request is taken only
//   once the previous one has committed (in_ready is high only while idle).
// Reset: synchronous, active high; empties the list and the mark, no RAM clearing.
`default_nettype none

`include "pool_free_list_allocator_assert.svh"

module pool_free_list_allocator #(
  parameter int POOL_SLOTS = 16,
  localparam int SW = $clog2(POOL_SLOTS),
  localparam int CW = $clog2(POOL_SLOTS + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // request channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       func,
  input  wire logic [SW-1:0]                    slot,
  input  wire logic signed [pfl_pkg::VAL_W-1:0] val_x,
  input  wire logic signed [pfl_pkg::VAL_W-1:0] val_y,
  input  wire logic signed [pfl_pkg::VAL_W-1:0] val_z,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            status,
  output logic [SW-1:0]                         slot_out,
  output logic signed [pfl_pkg::VAL_W-1:0]     rd_x,
  output logic signed [pfl_pkg::VAL_W-1:0]     rd_y,
  output logic signed [pfl_pkg::VAL_W-1:0]     rd_z,
  output logic [CW-1:0]                         free_count
);

  // A new request is taken while the previous result still waits in the output
  // reg; its commit then holds until that result drains.
  // Data of slots at or above the mark is never used, so the RAMs need no clearing pass.

  // capture: request taken, RAM reads issued
  // commit:  free-list update, RAM writes, result register load
  pfl_pkg::cmd_t cmd;

  pfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pfl_datapath #(.POOL_SLOTS(POOL_SLOTS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .func       (func),
    .slot       (slot),
    .val_x      (val_x),
    .val_y      (val_y),
    .val_z      (val_z),
    .status     (status),
    .slot_out   (slot_out),
    .rd_x       (rd_x),
    .rd_y       (rd_y),
    .rd_z       (rd_z),
    .free_count (free_count)
  );

  // one request in flight: no second capture right after a capture
  `PFL_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
                   "request taken during execute")

  // pool full only happens with an empty free list
  `PFL_ASSERT_NOW(a_full_empty, out_valid && status == pfl_pkg::STAT_FULL,
                  slot_out == '0 && free_count == '0,
                  "full result with nonempty list")

  // record fields are zero unless the status is ok
  `PFL_ASSERT_NOW(a_err_zero, out_valid && status != pfl_pkg::STAT_OK,
                  rd_x == '0 && rd_y == '0 && rd_z == '0,
                  "error result carries data")

endmodule

`default_nettype wire

[src/pfl_ram.sv]
// Generic single-write, single-read RAM with registered read.
`default_nettype none

module pfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/pfl_ctrl.sv]
// Controller FSM: request handshake, execute step, output valid.
`default_nettype none

module pfl_ctrl (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output pfl_pkg::cmd_t cmd
);

  pfl_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfl_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    cmd            = '0;
    in_ready       = 1'b0;
    if (out_ready) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      pfl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = pfl_pkg::ST_EXEC;
        end
      end
      pfl_pkg::ST_EXEC: begin
        // wait for the output register to drain
        if (!out_valid || out_ready) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = pfl_pkg::ST_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[src/pfl_datapath.sv]
// Datapath: request latch, free-list registers, RAMs and result register.
`default_nettype none

module pfl_datapath #(
  parameter int POOL_SLOTS = 16,
  localparam int SW = $clog2(POOL_SLOTS),
  localparam int CW = $clog2(POOL_SLOTS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pfl_pkg::cmd_t                 cmd,
  input  wire logic [1:0]                    func,
  input  wire logic [SW-1:0]                 slot,
  input  wire logic signed [pfl_pkg::VAL_W-1:0] val_x,
  input  wire logic signed [pfl_pkg::VAL_W-1:0] val_y,
  input  wire logic signed [pfl_pkg::VAL_W-1:0] val_z,
  output logic [1:0]                         status,
  output logic [SW-1:0]                      slot_out,
  output logic signed [pfl_pkg::VAL_W-1:0]   rd_x,
  output logic signed [pfl_pkg::VAL_W-1:0]   rd_y,
  output logic signed [pfl_pkg::VAL_W-1:0]   rd_z,
  output logic [CW-1:0]                      free_count
);

  localparam int VW = pfl_pkg::VAL_W;
  localparam int RW = pfl_pkg::REC_W;
  localparam logic [CW-1:0] SLOTS_C = CW'(POOL_SLOTS);

  // latched request
  pfl_pkg::func_e_t req_func;
  logic [SW-1:0]    req_slot;
  logic [RW-1:0]    req_rec;

  // free-list state
  logic [SW-1:0] head, head_next;
  logic [CW-1:0] hw, hw_next;
  logic [CW-1:0] count, count_next;

  // RAM ports
  logic [SW-1:0] link_rd;
  logic [0:0]    free_rd;
  logic [RW-1:0] rec_rd;
  logic          link_we, free_we, rec_we;
  logic [SW-1:0] link_waddr, free_waddr, rec_waddr;
  logic [0:0]    free_wdata;

  // execute-step decode
  logic [CW-1:0]           slot_ext;
  logic                    bad;
  logic [SW-1:0]           alloc_slot;
  logic [1:0]              status_next;
  logic [SW-1:0]           slot_out_next;
  logic [RW-1:0]           rd_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func <= pfl_pkg::func_e_t'(func);
      req_slot <= slot;
      req_rec  <= {val_z, val_y, val_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;  // don't-care while the list is empty
      hw    <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      head  <= head_next;
      hw    <= hw_next;
      count <= count_next;
    end
  end

  always_comb begin
    slot_ext      = CW'(req_slot);
    // slots at or above the mark were never handed out (also covers >= POOL_SLOTS)
    bad           = (slot_ext >= hw) || free_rd[0];
    alloc_slot    = (count != '0) ? head : hw[SW-1:0];
    head_next     = head;
    hw_next       = hw;
    count_next    = count;
    status_next   = pfl_pkg::STAT_OK;
    slot_out_next = req_slot;
    rd_next       = '0;
    link_we       = 1'b0;
    free_we       = 1'b0;
    rec_we        = 1'b0;
    link_waddr    = req_slot;
    free_waddr    = req_slot;
    free_wdata    = 1'b0;
    rec_waddr     = alloc_slot;
    unique case (req_func)
      pfl_pkg::FUNC_ALLOC: begin
        priority if (count != '0) begin
          // pop the head; its link was read at capture
          head_next     = link_rd;
          count_next    = count - CW'(1);
          rec_we        = 1'b1;
          free_we       = 1'b1;
          free_waddr    = alloc_slot;
          slot_out_next = alloc_slot;
        end else if (hw < SLOTS_C) begin
          hw_next       = hw + CW'(1);
          rec_we        = 1'b1;
          free_we       = 1'b1;
          free_waddr    = alloc_slot;
          slot_out_next = alloc_slot;
        end else begin
          status_next   = pfl_pkg::STAT_FULL;
          slot_out_next = '0;
        end
      end
      pfl_pkg::FUNC_FREE: begin
        if (bad) begin
          status_next = pfl_pkg::STAT_BAD;
        end else begin
          link_we    = 1'b1;
          free_we    = 1'b1;
          free_wdata = 1'b1;
          head_next  = req_slot;
          count_next = count + CW'(1);
        end
      end
      pfl_pkg::FUNC_READ: begin
        if (bad) begin
          status_next = pfl_pkg::STAT_BAD;
        end else begin
          rd_next = rec_rd;
        end
      end
      pfl_pkg::FUNC_NONE: begin
      end
    endcase
    link_we = link_we & cmd.commit;
    free_we = free_we & cmd.commit;
    rec_we  = rec_we & cmd.commit;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status     <= status_next;
      slot_out   <= slot_out_next;
      rd_x       <= $signed(rd_next[VW-1:0]);
      rd_y       <= $signed(rd_next[2*VW-1:VW]);
      rd_z       <= $signed(rd_next[3*VW-1:2*VW]);
      free_count <= count_next;
    end
  end

  // next-free links, read at the current head
  pfl_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (head),
    .re    (cmd.capture),
    .raddr (head),
    .rdata (link_rd)
  );

  // on-free-list flags; every slot below the mark has been written
  pfl_ram #(.WIDTH(1), .DEPTH(POOL_SLOTS)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .re    (cmd.capture),
    .raddr (slot),
    .rdata (free_rd)
  );

  pfl_ram #(.WIDTH(RW), .DEPTH(POOL_SLOTS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (req_rec),
    .re    (cmd.capture),
    .raddr (slot),
    .rdata (rec_rd)
  );

endmodule

`default_nettype wire

[dv/pool_free_list_allocator_test.sv]
// Self-checking testbench for the pool free-list allocator: directed and random requests.
module pool_free_list_allocator_test;

  localparam int SLOTS = 16;
  localparam int RAND_PER_PHASE = 160;

  logic clk;
  logic rst = 1'b1;

  // request side
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = 2'd0;
  logic [3:0] slot = 4'd0;
  logic signed [31:0] val_x = '0;
  logic signed [31:0] val_y = '0;
  logic signed [31:0] val_z = '0;

  // result side
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [3:0] slot_out;
  logic signed [31:0] rd_x;
  logic signed [31:0] rd_y;
  logic signed [31:0] rd_z;
  logic [4:0] free_count;

  pool_free_list_allocator #(
    .POOL_SLOTS(SLOTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .slot(slot),
    .val_x(val_x),
    .val_y(val_y),
    .val_z(val_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .slot_out(slot_out),
    .rd_x(rd_x),
    .rd_y(rd_y),
    .rd_z(rd_z),
    .free_count(free_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One pending request; drain holds it back until every reply is in.
  typedef struct {
    pfl_pkg::func_e_t fn;
    logic [3:0] s;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    int phase;
    bit drain;
  } pool_req_t;

  // One predicted reply.
  typedef struct {
    pfl_pkg::status_e_t st;
    logic [3:0] s;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [4:0] cnt;
  } pool_reply_t;

  pool_req_t req_q[$];
  pool_reply_t reply_q[$];

  // Idle/stall percentages per phase: none, sender, receiver, both.
  int send_idle[4] = '{0, 58, 0, 19};
  int recv_stall[4] = '{0, 0, 58, 19};
  int cur_phase = 0;
  logic req_fire = 1'b0;
  int errors = 0;
  int n_ok = 0;
  int n_full = 0;
  int n_bad = 0;
  int n_reads = 0;

  // ---------------------------------------------------------------------------
  // Predictor state: records, LIFO links, free flags, head, high-water, count.
  // ---------------------------------------------------------------------------
  logic signed [31:0] mem_x[SLOTS];
  logic signed [31:0] mem_y[SLOTS];
  logic signed [31:0] mem_z[SLOTS];
  int link[SLOTS];
  bit on_list[SLOTS];
  int head = SLOTS;
  int hw = 0;
  int nfree = 0;

  function automatic pool_reply_t pool_reply(logic [1:0] fn, logic [3:0] s,
                                             logic signed [31:0] x,
                                             logic signed [31:0] y,
                                             logic signed [31:0] z);
    pool_reply_t r;
    int g;
    r.st = pfl_pkg::STAT_OK;
    r.s = s;
    r.x = '0;
    r.y = '0;
    r.z = '0;
    case (fn)
      pfl_pkg::FUNC_ALLOC: begin
        // list first (emptiness from the count), then the high-water mark
        if (nfree > 0 && head < SLOTS) begin
          g = head;
          head = link[g];
          on_list[g] = 1'b0;
          nfree--;
        end else if (hw < SLOTS) begin
          g = hw;
          hw++;
        end else begin
          g = -1;
        end
        if (g >= 0) begin
          mem_x[g] = x;
          mem_y[g] = y;
          mem_z[g] = z;
          r.s = g[3:0];
        end else begin
          r.st = pfl_pkg::STAT_FULL;
          r.s = '0;
        end
      end
      pfl_pkg::FUNC_FREE: begin
        // at or above the mark or already free: rejected, nothing moves
        if (int'(s) >= hw || on_list[s]) begin
          r.st = pfl_pkg::STAT_BAD;
        end else begin
          link[s] = head;
          head = int'(s);
          on_list[s] = 1'b1;
          nfree++;
        end
      end
      pfl_pkg::FUNC_READ: begin
        if (int'(s) >= hw || on_list[s]) begin
          r.st = pfl_pkg::STAT_BAD;
        end else begin
          r.x = mem_x[s];
          r.y = mem_y[s];
          r.z = mem_z[s];
        end
      end
      default: begin
      end
    endcase
    r.cnt = 5'(nfree);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents requests at the falling edge. A new request goes out only
  // once the previous one was taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || req_fire) begin
        if (req_q.size() > 0 && !(req_q[0].drain && reply_q.size() > 0) &&
            $urandom_range(99) >= send_idle[req_q[0].phase]) begin
          in_valid <= 1'b1;
          func <= req_q[0].fn;
          slot <= req_q[0].s;
          val_x <= req_q[0].x;
          val_y <= req_q[0].y;
          val_z <= req_q[0].z;
          cur_phase <= req_q[0].phase;
          req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= $urandom_range(99) >= recv_stall[cur_phase];
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge, predict on each accepted request and check
  // each accepted reply against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    pool_reply_t want;
    req_fire <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      reply_q.push_back(pool_reply(func, slot, val_x, val_y, val_z));
    end
    if (!rst && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        report_mismatch("reply with no request pending", 32'(status), 32'hx);
      end else begin
        want = reply_q.pop_front();
        if (status !== want.st) report_mismatch("status", 32'(status), 32'(want.st));
        if (slot_out !== want.s) report_mismatch("slot_out", 32'(slot_out), 32'(want.s));
        if (rd_x !== want.x) report_mismatch("rd_x", rd_x, want.x);
        if (rd_y !== want.y) report_mismatch("rd_y", rd_y, want.y);
        if (rd_z !== want.z) report_mismatch("rd_z", rd_z, want.z);
        if (free_count !== want.cnt) begin
          report_mismatch("free_count", 32'(free_count), 32'(want.cnt));
        end
        case (want.st)
          pfl_pkg::STAT_OK: n_ok++;
          pfl_pkg::STAT_FULL: n_full++;
          default: n_bad++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus shadow: tracks which slots are live so random traffic can aim
  // frees and reads at real allocations. LIFO order mirrors the free list.
  // ---------------------------------------------------------------------------
  bit g_used[SLOTS];
  int g_stack[$];
  int g_hw = 0;

  function automatic logic [31:0] pick_val();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Slot below the mark that is live (want_live) or on the list; -1 if none.
  function automatic int pick_slot(bit want_live);
    int start;
    int idx;
    start = $urandom_range(SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      idx = (start + k) % SLOTS;
      if (idx < g_hw && g_used[idx] == want_live) return idx;
    end
    return -1;
  endfunction

  task automatic queue_req(pfl_pkg::func_e_t fn, int s, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, int phase, bit drain);
    pool_req_t r;
    r.fn = fn;
    r.s = s[3:0];
    r.x = x;
    r.y = y;
    r.z = z;
    r.phase = phase;
    r.drain = drain;
    req_q.push_back(r);
    if (fn == pfl_pkg::FUNC_ALLOC) begin
      if (g_stack.size() > 0) begin
        g_used[g_stack.pop_back()] = 1'b1;
      end else if (g_hw < SLOTS) begin
        g_used[g_hw] = 1'b1;
        g_hw++;
      end
    end else if (fn == pfl_pkg::FUNC_FREE && s < g_hw && g_used[s]) begin
      g_used[s] = 1'b0;
      g_stack.push_back(s);
    end
  endtask

  initial begin
    int made;
    int mode;
    int n;
    int s;
    bit first;
    pfl_pkg::func_e_t fn;

    // Directed: no-op, bad read/free on empty pool, fill with extreme records,
    // pool full, reads, double free, read of a freed slot, LIFO reuse.
    queue_req(pfl_pkg::FUNC_NONE, 15, '0, '0, '0, 0, 1'b0);
    queue_req(pfl_pkg::FUNC_READ, 0, '0, '0, '0, 0, 1'b0);
    queue_req(pfl_pkg::FUNC_FREE, 15, '0, '0, '0, 0, 1'b0);
    queue_req(pfl_pkg::FUNC_ALLOC, 15, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 0, 1'b0);
    queue_req(pfl_pkg::FUNC_ALLOC, 0, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 0, 1'b0);
    for (int i = 2; i < SLOTS; i++) begin
      queue_req(pfl_pkg::FUNC_ALLOC, ~i, pick_val(), pick_val(), pick_val(), 0, 1'b0);
    end
    queue_req(pfl_pkg::FUNC_ALLOC, 5, pick_val(), pick_val(), pick_val(), 0, 1'b0);
    queue_req(pfl_pkg::FUNC_READ, 0, '0, '0, '0, 0, 1'b0);
    queue_req(pfl_pkg::FUNC_FREE, 5, '0, '0, '0, 0, 1'b0);
    queue_req(pfl_pkg::FUNC_FREE, 5, '0, '0, '0, 0, 1'b0);
    queue_req(pfl_pkg::FUNC_READ, 5, '0, '0, '0, 0, 1'b0);
    queue_req(pfl_pkg::FUNC_FREE, 10, '0, '0, '0, 0, 1'b0);
    queue_req(pfl_pkg::FUNC_ALLOC, 0, pick_val(), pick_val(), pick_val(), 0, 1'b0);
    queue_req(pfl_pkg::FUNC_ALLOC, 0, pick_val(), pick_val(), pick_val(), 0, 1'b0);

    // Random: bursts of frees, allocs and reads on live slots, plus noise and
    // broken traffic. Each later phase opens by draining all replies.
    for (int ph = 0; ph < 4; ph++) begin
      made = 0;
      first = (ph > 0);
      while (made < RAND_PER_PHASE) begin
        mode = $urandom_range(9);
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          s = $urandom_range(SLOTS - 1);
          case (mode)
            0, 1, 2: begin
              s = pick_slot(1'b1);
              fn = (s < 0) ? pfl_pkg::FUNC_ALLOC : pfl_pkg::FUNC_FREE;
            end
            3, 4, 5: fn = pfl_pkg::FUNC_ALLOC;
            6, 7: begin
              if (pick_slot(1'b1) >= 0) s = pick_slot(1'b1);
              fn = pfl_pkg::FUNC_READ;
            end
            8: fn = pfl_pkg::func_e_t'($urandom_range(3));
            default: begin
              if (pick_slot(1'b0) >= 0) s = pick_slot(1'b0);
              fn = $urandom_range(1) ? pfl_pkg::FUNC_FREE : pfl_pkg::FUNC_READ;
            end
          endcase
          if (s < 0) s = $urandom_range(SLOTS - 1);
          queue_req(fn, s, pick_val(), pick_val(), pick_val(), ph, first);
          first = 1'b0;
          if (fn == pfl_pkg::FUNC_READ) n_reads++;
          if (fn != pfl_pkg::FUNC_NONE) made++;
        end
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all requests out and every reply back, then a short quiet tail
    while (req_q.size() > 0 || in_valid || reply_q.size() > 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (reply_q.size() > 0) begin
      report_mismatch("replies never returned", reply_q.size(), 0);
    end

    $display("Checked %0d ok, %0d pool-full and %0d rejected replies (%0d random reads)",
             n_ok, n_full, n_bad, n_reads);
    $display("across idle-free, sender-gap, receiver-stall and mixed phases.");
    if (errors == 0) begin
      $display("[pool_free_list_allocator] OK");
    end else begin
      $display("[pool_free_list_allocator] ERROR");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("[pool_free_list_allocator] ERROR");
    $finish;
  end

endmodule
